FILE: hw/rtl/rect_subtract_clip_top_macros.svh
// Assertion macros shared by the rectangle subtraction RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef RECT_SUBTRACT_CLIP_TOP_MACROS_SVH
`define RECT_SUBTRACT_CLIP_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define RSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsc: check failed");

// Next-cycle implication, held off while reset is high.
`define RSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsc: check failed");

`endif

FILE: hw/rtl/rsc_pkg.sv
// Types and constants of the rectangle subtraction block.
// Depends on nothing; used by every module of the block.
package rsc_pkg;

   localparam int COORD_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int FIELD_BITS     = 16;
   localparam int SIZE_BITS      = 15;
   localparam int EXT_BITS       = FIELD_BITS + 1;
   localparam int CSR_INDEX_BITS = 2;

   // Piece kinds, one bit each in a job mask, in emission order.
   localparam int PIECE_TOP    = 0;
   localparam int PIECE_BOTTOM = 1;
   localparam int PIECE_LEFT   = 2;
   localparam int PIECE_RIGHT  = 3;
   localparam int PIECE_WHOLE  = 4;
   localparam int PIECE_KINDS  = 5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CLIP_X,
      CSR_CLIP_Y,
      CSR_CLIP_WIDTH,
      CSR_CLIP_HEIGHT
   } csr_index_type;

   typedef logic signed [EXT_BITS-1:0] ext_coord_type;
   typedef logic [PIECE_KINDS-1:0]     piece_mask_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] x;
      logic signed [FIELD_BITS-1:0] y;
      logic [SIZE_BITS-1:0]         width;
      logic [SIZE_BITS-1:0]         height;
   } clip_cfg_type;

   typedef struct packed {
      ext_coord_type  x1;
      ext_coord_type  y1;
      ext_coord_type  x2;
      ext_coord_type  y2;
      ext_coord_type  kx1;
      ext_coord_type  kx2;
      ext_coord_type  ky1;
      ext_coord_type  ky2;
      piece_mask_type mask;
   } piece_job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

FILE: hw/rtl/rsc_queue.sv
// Job queue between the classifying front end and the piece emitter.
// Depends on rsc_pkg and the assertion macro header.
`include "rect_subtract_clip_top_macros.svh"

module rsc_queue #(
   parameter int DEPTH = rsc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  rsc_pkg::piece_job_type   push_job,
   input  logic                     pop,
   output rsc_pkg::piece_job_type   head_job,
   output rsc_pkg::queue_status_type status
);
   import rsc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   piece_job_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign push         = push_valid && !status.full;
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `RSC_ASSERT_IMPLY(a_pop_not_empty, clock, reset, pop, !status.empty)
   `RSC_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

FILE: hw/rtl/rsc_front.sv
// Front end: takes region rectangles, finds the overlap with the clip and
// queues a job with its piece mask. Depends on rsc_pkg and the macro header.
`include "rect_subtract_clip_top_macros.svh"

module rsc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  rsc_pkg::clip_cfg_type     clip,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [15:0]        req_rect_x,
   input  logic signed [15:0]        req_rect_y,
   input  logic [14:0]               req_rect_width,
   input  logic [14:0]               req_rect_height,
   output logic                      push_valid,
   input  rsc_pkg::queue_status_type status,
   output rsc_pkg::piece_job_type    push_job
);
   import rsc_pkg::*;

   // Stage A: edges of both rectangles.
   logic          a_valid_ff, a_valid_in;
   ext_coord_type a_x1_ff, a_y1_ff, a_x2_ff, a_y2_ff;
   ext_coord_type a_x3_ff, a_y3_ff, a_x4_ff, a_y4_ff;
   // Stage B: overlap window.
   logic          b_valid_ff, b_valid_in;
   ext_coord_type b_x1_ff, b_y1_ff, b_x2_ff, b_y2_ff;
   ext_coord_type b_kx1_ff, b_kx2_ff, b_ky1_ff, b_ky2_ff;

   ext_coord_type  x1_in, y1_in, x3_in, y3_in;
   logic           a_ready, b_ready, b_leave, overlap;
   piece_mask_type mask;

   assign x1_in = {req_rect_x[FIELD_BITS-1], req_rect_x};
   assign y1_in = {req_rect_y[FIELD_BITS-1], req_rect_y};
   assign x3_in = {clip.x[FIELD_BITS-1], clip.x};
   assign y3_in = {clip.y[FIELD_BITS-1], clip.y};

   // Touching edges count as overlap.
   always_comb begin
      mask    = '0;
      overlap = (b_ky1_ff <= b_ky2_ff) && (b_kx1_ff <= b_kx2_ff);
      if (overlap) begin
         mask[PIECE_TOP]    = b_y1_ff < b_ky1_ff;
         mask[PIECE_BOTTOM] = b_ky2_ff < b_y2_ff;
         mask[PIECE_LEFT]   = b_x1_ff < b_kx1_ff;
         mask[PIECE_RIGHT]  = b_kx2_ff < b_x2_ff;
      end else begin
         mask[PIECE_WHOLE]  = 1'b1;
      end
   end

   // Drop fully covered words here; they never reach the queue.
   assign push_valid = b_valid_ff && (mask != '0);
   assign b_leave    = (mask == '0) || !status.full;
   assign b_ready    = !b_valid_ff || b_leave;
   assign a_ready    = !a_valid_ff || b_ready;
   assign req_ready  = a_ready;

   assign push_job.x1   = b_x1_ff;
   assign push_job.y1   = b_y1_ff;
   assign push_job.x2   = b_x2_ff;
   assign push_job.y2   = b_y2_ff;
   assign push_job.kx1  = b_kx1_ff;
   assign push_job.kx2  = b_kx2_ff;
   assign push_job.ky1  = b_ky1_ff;
   assign push_job.ky2  = b_ky2_ff;
   assign push_job.mask = mask;

   always_comb begin
      a_valid_in = a_ready ? req_valid : a_valid_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && a_ready) begin
         a_x1_ff <= x1_in;
         a_y1_ff <= y1_in;
         a_x2_ff <= x1_in + ext_coord_type'({2'b00, req_rect_width});
         a_y2_ff <= y1_in + ext_coord_type'({2'b00, req_rect_height});
         a_x3_ff <= x3_in;
         a_y3_ff <= y3_in;
         a_x4_ff <= x3_in + ext_coord_type'({2'b00, clip.width});
         a_y4_ff <= y3_in + ext_coord_type'({2'b00, clip.height});
      end
      if (a_valid_ff && b_ready) begin
         b_x1_ff  <= a_x1_ff;
         b_y1_ff  <= a_y1_ff;
         b_x2_ff  <= a_x2_ff;
         b_y2_ff  <= a_y2_ff;
         b_kx1_ff <= (a_x1_ff > a_x3_ff) ? a_x1_ff : a_x3_ff;
         b_ky1_ff <= (a_y1_ff > a_y3_ff) ? a_y1_ff : a_y3_ff;
         b_kx2_ff <= (a_x2_ff < a_x4_ff) ? a_x2_ff : a_x4_ff;
         b_ky2_ff <= (a_y2_ff < a_y4_ff) ? a_y2_ff : a_y4_ff;
      end
   end

   `RSC_ASSERT_IMPLY(a_whole_alone, clock, reset, push_valid && push_job.mask[PIECE_WHOLE], $onehot(push_job.mask))

endmodule

FILE: hw/rtl/rsc_back.sv
// Back end: walks the head job's piece mask, one piece per cycle while
// rsp_ready is high, into the result register. Uses rsc_pkg, macros.
`include "rect_subtract_clip_top_macros.svh"

module rsc_back #(
   parameter int COORD_BITS = rsc_pkg::COORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rsc_pkg::queue_status_type status,
   input  rsc_pkg::piece_job_type    head_job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [15:0]        rsp_piece_x,
   output logic signed [15:0]        rsp_piece_y,
   output logic [15:0]               rsp_piece_width,
   output logic [15:0]               rsp_piece_height,
   output logic                      rsp_piece_last
);
   import rsc_pkg::*;

   localparam int WRAP_BITS  = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
   localparam int WRAP_SHIFT = EXT_BITS - WRAP_BITS;

   // Wrap to the coordinate width, then sign-extend into the field.
   function automatic logic [FIELD_BITS-1:0] wrap_coord(input ext_coord_type v);
      ext_coord_type up;
      ext_coord_type down;
      up   = v <<< WRAP_SHIFT;
      down = up >>> WRAP_SHIFT;
      return down[FIELD_BITS-1:0];
   endfunction

   piece_mask_type taken_ff, taken_in;
   piece_mask_type remaining, sel;
   logic           load, last;
   ext_coord_type  px, py, wa, wb, ha, hb, wd, hd;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] x_ff, y_ff, width_ff, height_ff;
   logic                  last_ff;

   assign remaining = head_job.mask & ~taken_ff;
   assign sel       = remaining & (~remaining + 1'b1);
   assign last      = (remaining & ~sel) == '0;
   assign load      = !status.empty && (!rsp_valid_ff || rsp_ready);
   assign pop       = load && last;

   always_comb begin
      unique case (1'b1)
         sel[PIECE_TOP]: begin
            px = head_job.x1;  py = head_job.y1;
            wa = head_job.x2;  wb = head_job.x1;
            ha = head_job.ky1; hb = head_job.y1;
         end
         sel[PIECE_BOTTOM]: begin
            px = head_job.x1;  py = head_job.ky2;
            wa = head_job.x2;  wb = head_job.x1;
            ha = head_job.y2;  hb = head_job.ky2;
         end
         sel[PIECE_LEFT]: begin
            px = head_job.x1;  py = head_job.ky1;
            wa = head_job.kx1; wb = head_job.x1;
            ha = head_job.ky2; hb = head_job.ky1;
         end
         sel[PIECE_RIGHT]: begin
            px = head_job.kx2; py = head_job.ky1;
            wa = head_job.x2;  wb = head_job.kx2;
            ha = head_job.ky2; hb = head_job.ky1;
         end
         default: begin
            px = head_job.x1;  py = head_job.y1;
            wa = head_job.x2;  wb = head_job.x1;
            ha = head_job.y2;  hb = head_job.y1;
         end
      endcase
      wd = wa - wb;
      hd = ha - hb;
   end

   always_comb begin
      taken_in     = taken_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         taken_in     = last ? '0 : (taken_ff | sel);
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff      <= wrap_coord(px);
         y_ff      <= wrap_coord(py);
         width_ff  <= wd[FIELD_BITS-1:0];
         height_ff <= hd[FIELD_BITS-1:0];
         last_ff   <= last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_piece_x      = x_ff;
   assign rsp_piece_y      = y_ff;
   assign rsp_piece_width  = width_ff;
   assign rsp_piece_height = height_ff;
   assign rsp_piece_last   = last_ff;

   `RSC_ASSERT_IMPLY(a_head_has_piece, clock, reset, !status.empty, remaining != '0)
   `RSC_ASSERT_NEXT(a_head_kept, clock, reset, load && !last, !status.empty)

endmodule

FILE: hw/rtl/rect_subtract_clip_top.sv
// Top level of the rectangle subtraction block: clip registers, front end,
// job queue and piece emitter. Depends on rsc_pkg, rsc_front, rsc_queue, rsc_back.
//
//   channel   direction  handshake                word
//   req_      in         req_valid / req_ready    one region rectangle
//   rsp_      out        rsp_valid / rsp_ready    one remaining piece
//   csr_      in         csr_write_en             one clip register write
//
// A rectangle yields one to four pieces; a fully covered one yields none
// and is dropped. The result channel sets the pace, one piece a cycle,
// from the emitter that walks the piece mask of the head job.
// The first piece passes stages A and B and the job queue to the result register.
// Synchronous reset clears the clip to zero and empties the pipeline.
// A stall on rsp_ fills the job queue before req_ready drops.

module rect_subtract_clip_top #(
   parameter int COORD_BITS  = rsc_pkg::COORD_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = rsc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [15:0]   req_rect_x,
   input  logic signed [15:0]   req_rect_y,
   input  logic [14:0]          req_rect_width,
   input  logic [14:0]          req_rect_height,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [15:0]   rsp_piece_x,
   output logic signed [15:0]   rsp_piece_y,
   output logic [15:0]          rsp_piece_width,
   output logic [15:0]          rsp_piece_height,
   output logic                 rsp_piece_last
);
   import rsc_pkg::*;

   clip_cfg_type     clip_ff, clip_in;
   piece_job_type    push_job, head_job;
   queue_status_type status;
   logic             push_valid, pop;

   // Clip registers; write them only while nothing is in flight, since each
   // word takes the clip at acceptance.
   always_comb begin
      clip_in = clip_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CLIP_X:      clip_in.x      = csr_wdata;
            CSR_CLIP_Y:      clip_in.y      = csr_wdata;
            CSR_CLIP_WIDTH:  clip_in.width  = csr_wdata[SIZE_BITS-1:0];
            CSR_CLIP_HEIGHT: clip_in.height = csr_wdata[SIZE_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= '0;
      end else begin
         clip_ff <= clip_in;
      end
   end

   // Front end: edges, overlap window and piece mask; drop covered words.
   rsc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .clip            (clip_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .push_valid      (push_valid),
      .status          (status),
      .push_job        (push_job)
   );

   // Hold jobs so that either side may stall on its own.
   rsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .status     (status)
   );

   // Emitter: advance through top, bottom, left, right, or the whole word.
   rsc_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .status           (status),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_piece_x      (rsp_piece_x),
      .rsp_piece_y      (rsp_piece_y),
      .rsp_piece_width  (rsp_piece_width),
      .rsp_piece_height (rsp_piece_height),
      .rsp_piece_last   (rsp_piece_last)
   );

endmodule
